// ----- design/ebtc_pkg.sv -----
package ebtc_pkg;

	localparam int unsigned DataWidth = 8;
	localparam int unsigned PrescaleWidth = 10;
	localparam int unsigned RegIndexWidth = 3;

	// Commands carried by an input request.
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_FORCE = 2'd3;

	// Waveform generation modes; the unused code runs as normal mode.
	localparam logic [1:0] WAVE_NORMAL = 2'd0;
	localparam logic [1:0] WAVE_CTC    = 2'd1;
	localparam logic [1:0] WAVE_PWM    = 2'd2;

	// Compare output modes.
	localparam logic [1:0] COM_OFF    = 2'd0;
	localparam logic [1:0] COM_TOGGLE = 2'd1;
	localparam logic [1:0] COM_CLEAR  = 2'd2;
	localparam logic [1:0] COM_SET    = 2'd3;

	// Clock select codes.
	localparam logic [2:0] CS_STOP    = 3'd0;
	localparam logic [2:0] CS_DIV1    = 3'd1;
	localparam logic [2:0] CS_DIV8    = 3'd2;
	localparam logic [2:0] CS_DIV64   = 3'd3;
	localparam logic [2:0] CS_DIV256  = 3'd4;
	localparam logic [2:0] CS_DIV1024 = 3'd5;

	// Register indexes on the configuration port.
	localparam logic [RegIndexWidth-1:0] REG_WAVE_MODE   = 3'd0;
	localparam logic [RegIndexWidth-1:0] REG_COM_MODE    = 3'd1;
	localparam logic [RegIndexWidth-1:0] REG_CLOCK_SEL   = 3'd2;
	localparam logic [RegIndexWidth-1:0] REG_COMPARE     = 3'd3;
	localparam logic [RegIndexWidth-1:0] REG_OVF_IRQ_EN  = 3'd4;
	localparam logic [RegIndexWidth-1:0] REG_CMP_IRQ_EN  = 3'd5;

	typedef struct packed {
		logic [1:0]           command;
		logic [DataWidth-1:0] write_data;
	} item_t;

	typedef struct packed {
		logic [DataWidth-1:0] count_value;
		logic                 overflow_flag;
		logic                 compare_flag;
		logic                 compare_pin;
		logic                 pin_driven;
		logic                 interrupt_request;
	} result_t;

	typedef struct packed {
		logic [1:0]           wave_mode;
		logic [1:0]           compare_output_mode;
		logic [2:0]           clock_select;
		logic [DataWidth-1:0] compare_value;
		logic                 overflow_irq_enable;
		logic                 compare_irq_enable;
	} cfg_t;

	// Low prescaler bits that must be zero for a timer clock.
	function automatic logic [PrescaleWidth-1:0] prescale_mask(input logic [2:0] sel);
		logic [PrescaleWidth-1:0] mask;
		case (sel)
			CS_DIV8:    mask = 10'h007;
			CS_DIV64:   mask = 10'h03f;
			CS_DIV256:  mask = 10'h0ff;
			CS_DIV1024: mask = 10'h3ff;
			default:    mask = 10'h000;
		endcase
		return mask;
	endfunction

	function automatic logic clock_running(input logic [2:0] sel);
		return (sel == CS_DIV1) || (sel == CS_DIV8) || (sel == CS_DIV64) ||
			(sel == CS_DIV256) || (sel == CS_DIV1024);
	endfunction

	// Output latch update on a compare match outside fast PWM.
	function automatic logic match_level(input logic [1:0] com, input logic level);
		logic next_level;
		case (com)
			COM_TOGGLE: next_level = ~level;
			COM_CLEAR:  next_level = 1'b0;
			COM_SET:    next_level = 1'b1;
			default:    next_level = level;
		endcase
		return next_level;
	endfunction

endpackage

// ----- design/ebtc_cfg.sv -----
module ebtc_cfg (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [ebtc_pkg::RegIndexWidth-1:0]       cfg_index,
	input  logic [ebtc_pkg::DataWidth-1:0]           cfg_data,
	output ebtc_pkg::cfg_t                           cfg
);
	import ebtc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WAVE_MODE:  cfg_q.wave_mode <= cfg_data[1:0];
				REG_COM_MODE:   cfg_q.compare_output_mode <= cfg_data[1:0];
				REG_CLOCK_SEL:  cfg_q.clock_select <= cfg_data[2:0];
				REG_COMPARE:    cfg_q.compare_value <= cfg_data;
				REG_OVF_IRQ_EN: cfg_q.overflow_irq_enable <= cfg_data[0];
				REG_CMP_IRQ_EN: cfg_q.compare_irq_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

// ----- design/ebtc_core.sv -----
module ebtc_core #(
	parameter int unsigned COUNT_WIDTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ebtc_pkg::cfg_t     cfg,
	input  logic               advance,
	input  ebtc_pkg::item_t    item_s1,
	output ebtc_pkg::result_t  result_s2
);
	import ebtc_pkg::*;

	logic [PrescaleWidth-1:0] prescale_q, prescale_d;
	logic [COUNT_WIDTH-1:0]   counter_q, counter_d, counter_inc;
	logic                     ovf_q, ovf_d;
	logic                     cmp_q, cmp_d;
	logic                     level_q, level_d;
	logic                     is_pwm, match, wrap, timer_clk, driven;
	result_t                  result_d;

	assign is_pwm = (cfg.wave_mode == WAVE_PWM);
	assign match = (counter_q == COUNT_WIDTH'(cfg.compare_value));
	assign wrap = &counter_q;
	assign counter_inc = counter_q + COUNT_WIDTH'(1);
	assign prescale_d = (item_s1.command == CMD_TICK && clock_running(cfg.clock_select)) ?
		prescale_q + PrescaleWidth'(1) : prescale_q;
	assign timer_clk = (item_s1.command == CMD_TICK) && clock_running(cfg.clock_select) &&
		((prescale_d & prescale_mask(cfg.clock_select)) == '0);
	assign driven = (cfg.compare_output_mode != COM_OFF) &&
		!(is_pwm && cfg.compare_output_mode == COM_TOGGLE);

	always_comb begin
		counter_d = counter_q;
		ovf_d = ovf_q;
		cmp_d = cmp_q;
		level_d = level_q;
		case (item_s1.command)
			CMD_TICK: begin
				if (timer_clk) begin
					if (cfg.wave_mode == WAVE_CTC) begin
						counter_d = match ? '0 : counter_inc;
						if (!match && wrap) ovf_d = 1'b1;
						if (match) begin
							cmp_d = 1'b1;
							level_d = match_level(cfg.compare_output_mode, level_q);
						end
					end else if (is_pwm) begin
						counter_d = counter_inc;
						if (match) begin
							cmp_d = 1'b1;
							if (cfg.compare_output_mode == COM_CLEAR) level_d = 1'b0;
							else if (cfg.compare_output_mode == COM_SET) level_d = 1'b1;
						end
						// Reaching bottom takes priority over a match on the same clock.
						if (wrap) begin
							ovf_d = 1'b1;
							if (cfg.compare_output_mode == COM_CLEAR) level_d = 1'b1;
							else if (cfg.compare_output_mode == COM_SET) level_d = 1'b0;
						end
					end else begin
						counter_d = counter_inc;
						if (wrap) ovf_d = 1'b1;
						if (match) begin
							cmp_d = 1'b1;
							level_d = match_level(cfg.compare_output_mode, level_q);
						end
					end
				end
			end
			CMD_WRITE: counter_d = COUNT_WIDTH'(item_s1.write_data);
			CMD_CLEAR: begin
				if (item_s1.write_data[0]) ovf_d = 1'b0;
				if (item_s1.write_data[1]) cmp_d = 1'b0;
			end
			default: begin
				if (!is_pwm) level_d = match_level(cfg.compare_output_mode, level_q);
			end
		endcase
	end

	always_comb begin
		result_d.count_value = counter_d[DataWidth-1:0];
		result_d.overflow_flag = ovf_d;
		result_d.compare_flag = cmp_d;
		result_d.compare_pin = level_d;
		result_d.pin_driven = driven;
		result_d.interrupt_request = (ovf_d & cfg.overflow_irq_enable) |
			(cmp_d & cfg.compare_irq_enable);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			counter_q <= '0;
			ovf_q <= 1'b0;
			cmp_q <= 1'b0;
			level_q <= 1'b0;
		end else if (advance) begin
			prescale_q <= prescale_d;
			counter_q <= counter_d;
			ovf_q <= ovf_d;
			cmp_q <= cmp_d;
			level_q <= level_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	property p_write_loads;
		@(posedge clk) disable iff (!arst_n)
		advance && item_s1.command == CMD_WRITE |=>
			counter_q == COUNT_WIDTH'($past(item_s1.write_data));
	endproperty
	a_write_loads: assert property (p_write_loads) else $error("count write not loaded");

	property p_clear_ovf;
		@(posedge clk) disable iff (!arst_n)
		advance && item_s1.command == CMD_CLEAR && item_s1.write_data[0] |=> !ovf_q;
	endproperty
	a_clear_ovf: assert property (p_clear_ovf) else $error("overflow flag not cleared");

	property p_count_held;
		@(posedge clk) disable iff (!arst_n)
		advance && (item_s1.command == CMD_CLEAR || item_s1.command == CMD_FORCE) |=>
			$stable(counter_q) && $stable(prescale_q);
	endproperty
	a_count_held: assert property (p_count_held) else $error("counter moved without a tick");

	property p_stopped;
		@(posedge clk) disable iff (!arst_n)
		advance && !clock_running(cfg.clock_select) |=> $stable(prescale_q);
	endproperty
	a_stopped: assert property (p_stopped) else $error("prescaler ran while stopped");

endmodule

// ----- design/eight_bit_timer_counter_pwm.sv -----
// A request accepted is registered into item_s1, and its result then into result_s2.
// One request per cycle while results are not stalled; timer state and result update together.
// The input stage stalls only while a finished result waits and is stalled itself.
// Reset (arst_n low) clears the prescaler, counter, flags, output latch,
// all configuration registers and both valid bits.
module eight_bit_timer_counter_pwm #(
	parameter int unsigned COUNT_WIDTH = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  ebtc_pkg::item_t                      item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output ebtc_pkg::result_t                    result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ebtc_pkg::RegIndexWidth-1:0]   cfg_index,
	input  logic [ebtc_pkg::DataWidth-1:0]       cfg_data
);
	import ebtc_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1, valid_s2, advance, accept;

	// The stage-one request moves on whenever the result register is free or being taken.
	assign advance = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept = item_valid && !item_stall;
	assign result_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) valid_s2 <= 1'b1;
			else if (!result_stall) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	ebtc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ebtc_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.advance   (advance),
		.item_s1   (item_s1),
		.result_s2 (result)
	);

endmodule

// ----- sim/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ebtc_pkg::*;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     item_valid   = 1'b0;
	logic                     item_stall;
	item_t                    item_bus     = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	result_t                  result_bus;
	logic                     cfg_valid    = 1'b0;
	logic                     cfg_ready;
	logic [RegIndexWidth-1:0] cfg_index    = '0;
	logic [DataWidth-1:0]     cfg_data     = '0;

	eight_bit_timer_counter_pwm i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_bus),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("eight_bit_timer_counter_pwm: mismatch");
		$finish;
	end

	// Timer state as the block should hold it.
	cfg_t                     timer_cfg      = '0;
	logic [PrescaleWidth-1:0] timer_prescale = '0;
	logic [DataWidth-1:0]     timer_count    = '0;
	logic                     timer_ovf      = 1'b0;
	logic                     timer_cmp      = 1'b0;
	logic                     timer_level    = 1'b0;

	result_t expected_results[$];
	int      errors = 0;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_serial   = 0;
	int hold_len      = 0;
	int hold_taken    = 0;
	int hold_left     = 0;

	function automatic logic compare_action(input logic level);
		case (timer_cfg.compare_output_mode)
			COM_TOGGLE: return ~level;
			COM_CLEAR:  return 1'b0;
			COM_SET:    return 1'b1;
			default:    return level;
		endcase
	endfunction

	// One timer clock; match and wrap look at the count before the clock.
	function automatic void timer_clock();
		logic [DataWidth-1:0] old;
		logic                 match;
		logic                 wrap;
		old   = timer_count;
		match = (old == timer_cfg.compare_value);
		wrap  = (old == 8'hff);
		case (timer_cfg.wave_mode)
			WAVE_CTC: begin
				if (match) begin
					timer_count = '0;
					timer_cmp   = 1'b1;
					timer_level = compare_action(timer_level);
				end else begin
					timer_count = old + 1'b1;
					if (wrap)
						timer_ovf = 1'b1;
				end
			end
			WAVE_PWM: begin
				timer_count = old + 1'b1;
				if (match) begin
					timer_cmp = 1'b1;
					if (timer_cfg.compare_output_mode == COM_CLEAR)
						timer_level = 1'b0;
					else if (timer_cfg.compare_output_mode == COM_SET)
						timer_level = 1'b1;
				end
				// Bottom is applied last so that it wins over a match.
				if (wrap) begin
					timer_ovf = 1'b1;
					if (timer_cfg.compare_output_mode == COM_CLEAR)
						timer_level = 1'b1;
					else if (timer_cfg.compare_output_mode == COM_SET)
						timer_level = 1'b0;
				end
			end
			default: begin
				timer_count = old + 1'b1;
				if (wrap)
					timer_ovf = 1'b1;
				if (match) begin
					timer_cmp   = 1'b1;
					timer_level = compare_action(timer_level);
				end
			end
		endcase
	endfunction

	function automatic void prescaler_tick();
		logic [PrescaleWidth-1:0] mask;
		case (timer_cfg.clock_select)
			CS_DIV1:    mask = 10'h000;
			CS_DIV8:    mask = 10'h007;
			CS_DIV64:   mask = 10'h03f;
			CS_DIV256:  mask = 10'h0ff;
			CS_DIV1024: mask = 10'h3ff;
			default:    return;
		endcase
		timer_prescale = timer_prescale + 1'b1;
		if ((timer_prescale & mask) == '0)
			timer_clock();
	endfunction

	function automatic result_t timer_step(input item_t it);
		result_t r;
		case (it.command)
			CMD_TICK:  prescaler_tick();
			CMD_WRITE: timer_count = it.write_data;
			CMD_CLEAR: begin
				if (it.write_data[0])
					timer_ovf = 1'b0;
				if (it.write_data[1])
					timer_cmp = 1'b0;
			end
			default: begin
				if (timer_cfg.wave_mode != WAVE_PWM)
					timer_level = compare_action(timer_level);
			end
		endcase
		r.count_value   = timer_count;
		r.overflow_flag = timer_ovf;
		r.compare_flag  = timer_cmp;
		r.compare_pin   = timer_level;
		r.pin_driven    = (timer_cfg.compare_output_mode != COM_OFF) &&
			!(timer_cfg.wave_mode == WAVE_PWM && timer_cfg.compare_output_mode == COM_TOGGLE);
		r.interrupt_request = (timer_ovf & timer_cfg.overflow_irq_enable) |
			(timer_cmp & timer_cfg.compare_irq_enable);
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endfunction

	// Result checking first, then the prediction for a request taken at this edge.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("result arrived with no request outstanding");
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("count_value", want.count_value, result_bus.count_value);
				check_field("overflow_flag", 8'(want.overflow_flag),
					8'(result_bus.overflow_flag));
				check_field("compare_flag", 8'(want.compare_flag),
					8'(result_bus.compare_flag));
				check_field("compare_pin", 8'(want.compare_pin),
					8'(result_bus.compare_pin));
				check_field("pin_driven", 8'(want.pin_driven),
					8'(result_bus.pin_driven));
				check_field("interrupt_request", 8'(want.interrupt_request),
					8'(result_bus.interrupt_request));
			end
		end
		if (arst_n && item_valid && !item_stall)
			expected_results.push_back(timer_step(item_bus));
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_serial != hold_taken) begin
			hold_taken = hold_serial;
			hold_left  = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_item(input logic [1:0] cmd, input logic [DataWidth-1:0] data);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid          <= 1'b1;
		item_bus.command    <= cmd;
		item_bus.write_data <= data;
		do @(posedge clk); while (item_stall);
	endtask

	// Stop sending and wait until every outstanding request has its result.
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [RegIndexWidth-1:0] idx,
		input logic [DataWidth-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input cfg_t c);
		settle();
		write_reg(REG_WAVE_MODE, DataWidth'(c.wave_mode));
		write_reg(REG_COM_MODE, DataWidth'(c.compare_output_mode));
		write_reg(REG_CLOCK_SEL, DataWidth'(c.clock_select));
		write_reg(REG_COMPARE, c.compare_value);
		write_reg(REG_OVF_IRQ_EN, DataWidth'(c.overflow_irq_enable));
		write_reg(REG_CMP_IRQ_EN, DataWidth'(c.compare_irq_enable));
		cfg_valid <= 1'b0;
		timer_cfg = c;
	endtask

	function automatic cfg_t random_cfg();
		cfg_t c;
		int   r;
		c.wave_mode           = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
		c.compare_output_mode = 2'($urandom_range(3));
		r = $urandom_range(9);
		if (r < 4)
			c.clock_select = CS_DIV1;
		else if (r < 7)
			c.clock_select = CS_DIV8;
		else if (r == 7)
			c.clock_select = CS_DIV64;
		else if (r == 8)
			c.clock_select = CS_STOP;
		else
			c.clock_select = 3'($urandom_range(4, 7));
		r = $urandom_range(3);
		c.compare_value = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom_range(255));
		c.overflow_irq_enable = 1'($urandom_range(1));
		c.compare_irq_enable  = 1'($urandom_range(1));
		return c;
	endfunction

	// Mostly ticks; half the count writes land near the compare value or the top
	// so that matches and wraps come often.
	function automatic item_t random_item();
		item_t it;
		int    r;
		it.write_data = 8'($urandom_range(255));
		r = $urandom_range(99);
		if (r < 65) begin
			it.command = CMD_TICK;
		end else if (r < 78) begin
			it.command = CMD_WRITE;
			case ($urandom_range(3))
				0: it.write_data = timer_cfg.compare_value - 8'($urandom_range(3));
				1: it.write_data = 8'hff - 8'($urandom_range(3));
				default: ;
			endcase
		end else if (r < 92) begin
			it.command = CMD_CLEAR;
		end else begin
			it.command = CMD_FORCE;
		end
		return it;
	endfunction

	task automatic send_random(input int count);
		item_t it;
		repeat (count) begin
			it = random_item();
			send_item(it.command, it.write_data);
		end
	endtask

	task automatic test_normal_mode();
		configure('{WAVE_NORMAL, COM_TOGGLE, CS_DIV1, 8'd2, 1'b1, 1'b1});
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TICK, 8'hff);
		send_item(CMD_TICK, 8'h55);
		send_item(CMD_WRITE, 8'hff);
		send_item(CMD_TICK, 8'haa);
		send_item(CMD_CLEAR, 8'h00);
		send_item(CMD_CLEAR, 8'h01);
		send_item(CMD_CLEAR, 8'h02);
		send_item(CMD_FORCE, 8'hff);
		// A count write right before a match does not block it.
		send_item(CMD_WRITE, 8'h02);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_CLEAR, 8'hff);
		// The unused wave code runs as normal mode; a stopped clock holds all.
		configure('{2'd3, COM_SET, CS_STOP, 8'hff, 1'b0, 1'b1});
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_WRITE, 8'hff);
		send_item(CMD_FORCE, 8'h00);
		configure('{2'd3, COM_CLEAR, 3'd7, 8'hff, 1'b1, 1'b0});
		send_item(CMD_TICK, 8'h00);
	endtask

	task automatic test_ctc_and_pwm();
		configure('{WAVE_CTC, COM_CLEAR, CS_DIV1, 8'h00, 1'b1, 1'b1});
		send_item(CMD_WRITE, 8'h00);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TICK, 8'h00);
		configure('{WAVE_CTC, COM_TOGGLE, CS_DIV1, 8'hff, 1'b0, 1'b1});
		send_item(CMD_WRITE, 8'hfe);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_FORCE, 8'h00);
		// Match and bottom on one clock: bottom decides the pin.
		configure('{WAVE_PWM, COM_CLEAR, CS_DIV1, 8'hff, 1'b1, 1'b0});
		send_item(CMD_WRITE, 8'hfe);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_FORCE, 8'h00);
		configure('{WAVE_PWM, COM_SET, CS_DIV1, 8'h10, 1'b1, 1'b1});
		send_item(CMD_WRITE, 8'h0f);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TICK, 8'h00);
		configure('{WAVE_PWM, COM_TOGGLE, CS_DIV1, 8'h11, 1'b1, 1'b1});
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_FORCE, 8'h00);
	endtask

	// The slow dividers only fire when the prescaler comes round. The divide by
	// 256 run stops one short of the wrap, which the divide by 1024 run then takes.
	task automatic test_slow_dividers();
		int n;
		configure('{WAVE_CTC, COM_SET, CS_DIV256, 8'h02, 1'b0, 1'b0});
		n = 1023 - int'(timer_prescale);
		repeat (n) send_item(CMD_TICK, 8'($urandom_range(255)));
		configure('{WAVE_NORMAL, COM_TOGGLE, CS_DIV1024, 8'h40, 1'b1, 1'b1});
		repeat (3) send_item(CMD_TICK, 8'h00);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		configure('{WAVE_NORMAL, COM_TOGGLE, CS_DIV1, 8'h20, 1'b1, 1'b1});
		hold_len = 150;
		hold_serial++;
		send_random(40);
		// The sender waits here until every result is back.
		settle();
		send_random(20);
	endtask

	task automatic test_random_phases();
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 52; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 52; end
				default: begin send_idle_pct = 24; stall_pct = 24; end
			endcase
			configure(random_cfg());
			send_random(20);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_normal_mode();
		test_ctc_and_pwm();
		test_slow_dividers();
		test_backpressure();
		test_random_phases();
		settle();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("eight_bit_timer_counter_pwm: match");
		end else begin
			$display("eight_bit_timer_counter_pwm: mismatch");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/ebtc_pkg.sv
design/ebtc_cfg.sv
design/ebtc_core.sv
design/eight_bit_timer_counter_pwm.sv
sim/testbench.sv
